// ----- rtl/scc_pkg.sv -----
// scc_pkg: shared types and constants of the column span clipper
// used by scc_front, scc_queue, scc_back and solid_column_span_clipper
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

    // column count bound and field widths
    localparam int MAX_COLUMNS_DEF = 128;
    localparam int COL_W           = 8;
    localparam int RUN_W           = 7;
    localparam int IN_DATA_W       = 24;
    localparam int OUT_DATA_W      = 16;

    // configuration port
    localparam int ADDR_W = 3;
    localparam int APB_W  = 32;
    localparam logic REG_ACTIVE_WIDTH = 1'b0;
    localparam logic [COL_W-1:0] ACTIVE_WIDTH_RST = 8'd128;

    // input command codes
    localparam logic CMD_CLEAR = 1'b0;
    localparam logic CMD_CLIP  = 1'b1;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    // classified operation carried through the queue
    typedef struct packed {
        logic is_clear;
        logic solid;
    } scc_op_t;

endpackage

`default_nettype wire

// ----- rtl/scc_front.sv -----
// scc_front: accepts input transactions and turns each into an operation and a column mask
// depends on scc_pkg
`timescale 1ns / 1ps
`default_nettype none

module scc_front
    import scc_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
)
(
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_DATA_W-1:0]   s_tdata,
    input  wire logic [0:0]             s_tuser,
    input  wire logic [COL_W-1:0]       active_width,
    input  wire logic                   q_full,
    output logic                        push,
    output scc_op_t                     push_op,
    output logic [MAX_COLUMNS-1:0]      push_mask
);

    logic [COL_W-1:0] first_col;
    logic [COL_W-1:0] end_col;
    logic             solid_mark;
    logic             is_clear;

    // unpack payload
    assign first_col  = s_tdata[COL_W-1:0];
    assign end_col    = s_tdata[2*COL_W-1:COL_W];
    assign solid_mark = s_tdata[2*COL_W];
    assign is_clear   = (s_tuser[0] == CMD_CLEAR);

    // accept whenever the queue has room
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // classify the transaction
    always_comb
    begin
        push_op.is_clear = is_clear;
        push_op.solid    = solid_mark && !is_clear;
    end

    // per-column mask: active width for a clear, span for a clip
    // columns lie below the saturation bound, so raw bounds compare the same
    always_comb
    begin
        for (int c = 0; c < MAX_COLUMNS; c++)
        begin
            if (is_clear)
                push_mask[c] = (COL_W'(c) < active_width);
            else
                push_mask[c] = (COL_W'(c) >= first_col) && (COL_W'(c) < end_col);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/scc_queue.sv -----
// scc_queue: short first-in first-out queue of classified operations
// depends on scc_pkg
`timescale 1ns / 1ps
`default_nettype none

module scc_queue
    import scc_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  full,
    output logic                  not_empty
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]  entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = entry_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ----- rtl/scc_back.sv -----
// scc_back: holds the column occlusion bits and emits one open run per unstalled cycle
// depends on scc_pkg
`timescale 1ns / 1ps
`default_nettype none

module scc_back
    import scc_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_not_empty,
    input  wire scc_op_t                q_op,
    input  wire logic [MAX_COLUMNS-1:0] q_mask,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [RUN_W-1:0]            run_start,
    output logic [RUN_W-1:0]            run_end,
    output logic                        has_run,
    output logic                        last_item
);

    localparam int IW = $clog2(MAX_COLUMNS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [MAX_COLUMNS-1:0] occ_reg;
    logic [MAX_COLUMNS-1:0] occ_next;
    logic [MAX_COLUMNS-1:0] rem_reg;
    logic [MAX_COLUMNS-1:0] rem_next;
    logic                   solid_reg;
    logic                   solid_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [RUN_W-1:0]       out_start_reg;
    logic [RUN_W-1:0]       out_start_next;
    logic [RUN_W-1:0]       out_end_reg;
    logic [RUN_W-1:0]       out_end_next;
    logic                   out_has_reg;
    logic                   out_has_next;
    logic                   out_last_reg;
    logic                   out_last_next;

    logic                   emit_ok;
    logic [MAX_COLUMNS-1:0] low_bit;
    logic [MAX_COLUMNS-1:0] carry_sum;
    logic [MAX_COLUMNS-1:0] run_bits;
    logic [MAX_COLUMNS-1:0] rest_bits;
    logic [IW-1:0]          start_idx;
    logic [IW-1:0]          end_idx;

    // output register frees up when empty or being taken
    assign emit_ok = !out_valid_reg || m_tready;

    // isolate the lowest open run of the remaining span bits
    assign low_bit   = rem_reg & (~rem_reg + 1'b1);
    assign carry_sum = rem_reg + low_bit;
    assign run_bits  = rem_reg & ~carry_sum;
    assign rest_bits = rem_reg & carry_sum;

    // run start: lowest open column
    always_comb
    begin
        start_idx = '0;
        for (int c = MAX_COLUMNS - 1; c >= 0; c--)
        begin
            if (rem_reg[c])
                start_idx = IW'(c);
        end
    end

    // run end: highest column of the isolated run
    always_comb
    begin
        end_idx = '0;
        for (int c = 0; c < MAX_COLUMNS; c++)
        begin
            if (run_bits[c])
                end_idx = IW'(c);
        end
    end

    // sequencer: take an operation, then for a clip one run per cycle while the output is free
    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        rem_next       = rem_reg;
        solid_next     = solid_reg;
        q_pop          = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        out_start_next = out_start_reg;
        out_end_next   = out_end_reg;
        out_has_next   = out_has_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop = 1'b1;
                    if (q_op.is_clear)
                        occ_next = occ_reg & ~q_mask;
                    else
                    begin
                        rem_next   = ~occ_reg & q_mask;
                        solid_next = q_op.solid;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    out_has_next   = (rem_reg != '0);
                    out_start_next = (rem_reg != '0) ? RUN_W'(start_idx) : '0;
                    out_end_next   = (rem_reg != '0) ? RUN_W'(end_idx) : '0;
                    out_last_next  = (rest_bits == '0);
                    rem_next       = rest_bits;
                    if (solid_reg)
                        occ_next = occ_reg | run_bits;
                    if (rest_bits == '0)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        solid_reg     <= solid_next;
        out_start_reg <= out_start_next;
        out_end_reg   <= out_end_next;
        out_has_reg   <= out_has_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid  = out_valid_reg;
    assign run_start = out_start_reg;
    assign run_end   = out_end_reg;
    assign has_run   = out_has_reg;
    assign last_item = out_last_reg;

    // an empty finish always closes the transaction
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_has_reg) |-> out_last_reg)
        else $error("empty result without last flag");

    // a reported run is never reversed
    a_run_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_has_reg) |-> (out_start_reg <= out_end_reg))
        else $error("run start above run end");

    // a run that is not the last keeps the sequencer busy
    a_more_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && emit_ok && rest_bits != '0) |=> (state_reg == ST_RUN))
        else $error("sequencer left with runs pending");

    // a solid clip closes the columns it reported
    a_solid_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && emit_ok && solid_reg)
            |=> ((occ_reg & $past(run_bits)) == $past(run_bits)))
        else $error("solid run left open");

endmodule

`default_nettype wire

// ----- rtl/solid_column_span_clipper.sv -----
// solid_column_span_clipper: top level, configuration register and wiring of front, queue, back
// depends on scc_pkg, scc_front, scc_queue, scc_back
//
// channel   direction  handshake                 payload
// s_*       in         s_tvalid / s_tready       s_tuser: command; s_tdata: first_col, end_col, solid_mark
// m_*       out        m_tvalid / m_tready       m_tuser: has_run; m_tdata: run_start, run_end; m_tlast
// apb       in         psel, penable, pready     paddr, pwdata, prdata: active_width at byte 0
//
// a clear is applied in the back end as it is popped; a clip first loads its span
// and then emits one open run per cycle while the output is free, or a single empty finish
// the back end finds one run per unstalled cycle with a carry-isolate and two priority encoders
// a two-entry command queue lets the input side keep accepting while runs drain
// reset opens every column and sets active_width to 128; no clearing pass is needed
// a stalled output holds the back end, which fills the queue and then drops s_tready
`timescale 1ns / 1ps
`default_nettype none

module solid_column_span_clipper
    import scc_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // first_col[7:0], end_col[15:8], solid_mark[16]
    input  wire logic [0:0]            s_tuser,   // command[0]
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // run_start[6:0], run_end[13:7]
    output logic [0:0]                 m_tuser,   // has_run[0]
    output logic                       m_tlast,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [APB_W-1:0]      pwdata,
    output logic [APB_W-1:0]           prdata,
    output logic                       pready
);

    localparam int Q_W = $bits(scc_op_t) + MAX_COLUMNS;

    logic [COL_W-1:0]       active_width_reg;
    logic [COL_W-1:0]       active_width_next;
    logic                   cfg_write;
    logic                   q_full;
    logic                   q_not_empty;
    logic                   push;
    logic                   pop;
    scc_op_t                push_op;
    logic [MAX_COLUMNS-1:0] push_mask;
    logic [Q_W-1:0]         pop_data;
    scc_op_t                pop_op;
    logic [MAX_COLUMNS-1:0] pop_mask;
    logic [RUN_W-1:0]       run_start;
    logic [RUN_W-1:0]       run_end;
    logic                   has_run;
    logic                   last_item;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[ADDR_W-1] == REG_ACTIVE_WIDTH);

    always_comb
    begin
        active_width_next = active_width_reg;
        if (cfg_write)
            active_width_next = pwdata[COL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_width_reg <= ACTIVE_WIDTH_RST;
        else
            active_width_reg <= active_width_next;
    end

    // read back
    always_comb
    begin
        prdata = '0;
        if (paddr[ADDR_W-1] == REG_ACTIVE_WIDTH)
            prdata = {{(APB_W-COL_W){1'b0}}, active_width_reg};
    end

    // front: accept and classify
    scc_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .active_width (active_width_reg),
        .q_full       (q_full),
        .push         (push),
        .push_op      (push_op),
        .push_mask    (push_mask)
    );

    // command queue
    scc_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_op, push_mask}),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    assign pop_op   = pop_data[Q_W-1:MAX_COLUMNS];
    assign pop_mask = pop_data[MAX_COLUMNS-1:0];

    // back: column bits and run emission
    scc_back #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_op        (pop_op),
        .q_mask      (pop_mask),
        .q_pop       (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .run_start   (run_start),
        .run_end     (run_end),
        .has_run     (has_run),
        .last_item   (last_item)
    );

    // pack result transaction
    assign m_tdata = {{(OUT_DATA_W-2*RUN_W){1'b0}}, run_end, run_start};
    assign m_tuser = has_run;
    assign m_tlast = last_item;

endmodule

`default_nettype wire
